// File: sv/trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg: shared types and constants of the touch report parser
// Holds the input and result word formats and the decoding constants.
// ----------------------------------------------------------------------------
package trp_pkg;

  // default number of points a report may carry
  localparam int unsigned MaxPointsDefault = 5;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OffsetW = 7;
  localparam int unsigned XW      = 10;
  localparam int unsigned YW      = 9;
  localparam int unsigned RawW    = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  // status byte layout
  localparam int unsigned StatusReadyBit = 7;

  // panel limits
  localparam logic [XW-1:0] XMax = 10'd799;
  localparam logic [YW-1:0] YMax = 9'd479;

  // scaling: x*799/1023 and y*479/599 as rounded reciprocal multiplies, 20 fraction bits
  localparam int unsigned    ScaleShift = 20;
  localparam int unsigned    ProdW      = 30;
  localparam logic [19:0]    ScaleXMul  = 20'd818976;
  localparam logic [19:0]    ScaleYMul  = 20'd838511;
  // at or above these raw values the scaled result always clamps
  localparam logic [RawW-1:0] ScaleXLimit = 16'd1023;
  localparam logic [RawW-1:0] ScaleYLimit = 16'd600;

  // release counter
  localparam logic [ByteW-1:0] ReleaseSatMax      = 8'd255;
  localparam logic [ByteW-1:0] ReleaseThresholdRst = 8'd3;

  // register word addresses (byte address 4*i)
  localparam logic REG_SCALE_ENABLE      = 1'b0;
  localparam logic REG_RELEASE_THRESHOLD = 1'b1;

  // byte positions inside an 8-byte point record
  localparam logic [2:0] POS_X_LOW  = 3'd1;
  localparam logic [2:0] POS_X_HIGH = 3'd2;
  localparam logic [2:0] POS_Y_LOW  = 3'd3;
  localparam logic [2:0] POS_Y_HIGH = 3'd4;

  // event codes
  localparam logic EVENT_POINT   = 1'b0;
  localparam logic EVENT_RELEASE = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] report_byte;
    logic             report_start;
    logic             read_failed;
  } in_word_t;

  typedef struct packed {
    logic              event_kind;
    logic [CountW-1:0] point_index;
    logic [CountW-1:0] touch_count;
    logic [XW-1:0]     point_x;
    logic [YW-1:0]     point_y;
    logic              last_point;
  } out_word_t;

endpackage

// File: sv/touch_report_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_parser: decodes touch controller reports one byte at a time
// An accepted byte is held in the input register and passes the parse and
// scale logic; its result word is captured in the result register.
// Throughput: one byte per cycle, limited only by the output stall.
// Reset: asynchronous active low; clears parse state, release counter and
// registers (scale off, release threshold 3); no report is armed.
// ----------------------------------------------------------------------------
module touch_report_parser import trp_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // byte input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxPoints);

  // configuration registers
  logic             scale_en_q;
  logic [ByteW-1:0] threshold_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_en_q  <= 1'b0;
      threshold_q <= ReleaseThresholdRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SCALE_ENABLE:      scale_en_q  <= pwdata[0];
        REG_RELEASE_THRESHOLD: threshold_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALE_ENABLE:      prdata = {{(CfgDataW-1){1'b0}}, scale_en_q};
      REG_RELEASE_THRESHOLD: prdata = {{(CfgDataW-ByteW){1'b0}}, threshold_q};
      default:               prdata = '0;
    endcase
  end

  // pipeline handshake
  logic     in_vld_q;
  in_word_t in_word_q;
  logic     out_vld_q;
  out_word_t out_word_q;
  logic     advance;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_vld_q || advance) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  // parse state
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [CountW-1:0]  active_q, active_d;
  logic [RawW-1:0]    raw_x_q, raw_x_d;
  logic [RawW-1:0]    raw_y_q, raw_y_d;
  logic [ByteW-1:0]   release_q, release_d;

  // byte decode
  logic [ByteW-1:0]  b;
  logic [CountW-1:0] status_cnt;
  logic [CountW-1:0] idx;
  logic [2:0]        pos;
  logic [ByteW-1:0]  release_inc;
  logic [RawW-1:0]   y_full;
  logic              last;
  logic              emit;
  out_word_t         result;

  assign b           = in_word_q.report_byte;
  assign status_cnt  = b[CountW-1:0];
  assign idx         = offset_q[OffsetW-1:3];
  assign pos         = offset_q[2:0];
  assign release_inc = (release_q < ReleaseSatMax) ? release_q + 8'd1 : release_q;
  assign y_full      = {b, raw_y_q[7:0]};
  assign last        = (idx + CountW'(1)) == active_q;

  // coordinate scaling and clamping
  logic [ProdW-1:0] x_prod;
  logic [ProdW-1:0] y_prod;
  logic [XW-1:0]    x_out;
  logic [YW-1:0]    y_out;

  assign x_prod = ProdW'(raw_x_q[9:0]) * ProdW'(ScaleXMul);
  assign y_prod = ProdW'(y_full[9:0]) * ProdW'(ScaleYMul);

  always_comb begin
    if (scale_en_q) begin
      x_out = (raw_x_q >= ScaleXLimit) ? XMax : x_prod[ScaleShift +: XW];
      y_out = (y_full >= ScaleYLimit) ? YMax : y_prod[ScaleShift +: YW];
    end else begin
      x_out = (raw_x_q > RawW'(XMax)) ? XMax : raw_x_q[XW-1:0];
      y_out = (y_full > RawW'(YMax)) ? YMax : y_full[YW-1:0];
    end
  end

  // report parsing
  always_comb begin
    offset_d  = offset_q;
    active_d  = active_q;
    raw_x_d   = raw_x_q;
    raw_y_d   = raw_y_q;
    release_d = release_q;
    emit      = 1'b0;
    result    = '0;

    if (in_word_q.read_failed) begin
      // failed read aborts the report
      active_d = '0;
      offset_d = '0;
    end else if (in_word_q.report_start) begin
      // status byte always ends the previous report
      active_d = '0;
      offset_d = '0;
      if (b[StatusReadyBit]) begin
        if (status_cnt != '0 && status_cnt <= MaxCount) begin
          active_d = status_cnt;
        end else begin
          release_d = release_inc;
          if (release_inc >= threshold_q) begin
            emit              = 1'b1;
            result.event_kind = EVENT_RELEASE;
            result.last_point = 1'b1;
          end
        end
      end
    end else if (active_q != '0) begin
      offset_d = offset_q + OffsetW'(1);
      if (idx >= active_q) begin
        // past the last record
        active_d = '0;
        offset_d = '0;
      end else begin
        case (pos)
          POS_X_LOW:  raw_x_d = {raw_x_q[15:8], b};
          POS_X_HIGH: raw_x_d = {b, raw_x_q[7:0]};
          POS_Y_LOW:  raw_y_d = {raw_y_q[15:8], b};
          POS_Y_HIGH: begin
            raw_y_d            = y_full;
            emit               = 1'b1;
            result.event_kind  = EVENT_POINT;
            result.point_index = idx;
            result.touch_count = active_q;
            result.point_x     = x_out;
            result.point_y     = y_out;
            result.last_point  = last;
            if (last) begin
              release_d = '0;
              active_d  = '0;
              offset_d  = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      active_q  <= '0;
      raw_x_q   <= '0;
      raw_y_q   <= '0;
      release_q <= '0;
    end else if (in_vld_q && advance) begin
      offset_q  <= offset_d;
      active_q  <= active_d;
      raw_x_q   <= raw_x_d;
      raw_y_q   <= raw_y_d;
      release_q <= release_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_vld_q && emit) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_word_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for touch_report_parser
// Feeds status bytes and point records through the byte channel and predicts
// every result word with a behavioral decoder kept inside the bench. Directed
// tests cover coordinate extremes, scaling, clamping, aborted and malformed
// reports and release counting; random phases then send mostly well-formed
// reports with random content under varying sender gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import trp_pkg::*;

  localparam int unsigned PanelXFull    = 1023;
  localparam int unsigned PanelYFull    = 599;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReported   = 10;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_word_t            in_word;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // decoder state mirrored by the bench
  logic              cfg_scale;
  logic [ByteW-1:0]  cfg_threshold;
  logic [OffsetW-1:0] rec_offset;
  logic [CountW-1:0] armed_count;
  logic [RawW-1:0]   raw_x;
  logic [RawW-1:0]   raw_y;
  logic [ByteW-1:0]  empty_reports;

  out_word_t   pending_events[$];
  out_word_t   oldest_event;
  int unsigned error_count = 0;
  int unsigned bytes_sent;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned corrupt_pct;

  touch_report_parser i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predict the result words caused by one accepted byte
  function void decode_byte(input in_word_t w);
    out_word_t        ev;
    logic [OffsetW-1:0] rel;
    logic [CountW-1:0] idx;
    logic [2:0]       pos;
    int unsigned      sx;
    int unsigned      sy;
    ev = '0;
    // a failed read kills the report but keeps the release count
    if (w.read_failed) begin
      armed_count = '0;
      rec_offset = '0;
      return;
    end
    // status byte always ends the previous report
    if (w.report_start) begin
      armed_count = '0;
      rec_offset = '0;
      if (!w.report_byte[StatusReadyBit]) return;
      if (w.report_byte[3:0] >= 4'd1 &&
          w.report_byte[3:0] <= 4'(MaxPointsDefault)) begin
        armed_count = w.report_byte[3:0];
        return;
      end
      if (empty_reports != ReleaseSatMax) empty_reports = empty_reports + 1'b1;
      if (empty_reports >= cfg_threshold) begin
        ev.event_kind = EVENT_RELEASE;
        ev.last_point = 1'b1;
        pending_events.push_back(ev);
      end
      return;
    end
    // stray byte with no report armed
    if (armed_count == '0) return;
    rec_offset = rec_offset + 1'b1;
    rel = rec_offset - 1'b1;
    idx = rel[OffsetW-1:3];
    pos = rel[2:0];
    if (idx >= armed_count) begin
      armed_count = '0;
      rec_offset = '0;
      return;
    end
    case (pos)
      POS_X_LOW: begin
        raw_x[7:0] = w.report_byte;
      end
      POS_X_HIGH: begin
        raw_x[15:8] = w.report_byte;
      end
      POS_Y_LOW: begin
        raw_y[7:0] = w.report_byte;
      end
      POS_Y_HIGH: begin
        raw_y[15:8] = w.report_byte;
        sx = 32'(raw_x);
        sy = 32'(raw_y);
        if (cfg_scale) begin
          sx = sx * 32'(XMax) / PanelXFull;
          sy = sy * 32'(YMax) / PanelYFull;
        end
        if (sx > 32'(XMax)) sx = 32'(XMax);
        if (sy > 32'(YMax)) sy = 32'(YMax);
        ev.event_kind  = EVENT_POINT;
        ev.point_index = idx;
        ev.touch_count = armed_count;
        ev.point_x     = sx[XW-1:0];
        ev.point_y     = sy[YW-1:0];
        ev.last_point  = (idx + 1'b1 == armed_count);
        pending_events.push_back(ev);
        if (ev.last_point) begin
          empty_reports = '0;
          armed_count = '0;
          rec_offset = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function in_word_t status_word(input logic [7:0] b);
    in_word_t w;
    w = '0;
    w.report_byte = b;
    w.report_start = 1'b1;
    return w;
  endfunction

  // send one word, with random sender gaps, and predict it on acceptance
  task send_word(input in_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(w);
    bytes_sent++;
  endtask

  // report body byte, sometimes replaced by a failed read
  task send_data(input logic [7:0] b);
    in_word_t w;
    w = '0;
    w.report_byte = b;
    if ($urandom_range(0, 99) < corrupt_pct) begin
      w.report_byte = 8'($urandom);
      w.report_start = 1'($urandom);
      w.read_failed = 1'b1;
    end
    send_word(w);
  endtask

  // one point record; the tail bytes are left off on a report's last point
  task send_point(input logic [15:0] x, input logic [15:0] y, input logic full);
    send_data(8'($urandom));
    send_data(x[7:0]);
    send_data(x[15:8]);
    send_data(y[7:0]);
    send_data(y[15:8]);
    if (full) repeat (3) send_data(8'($urandom));
  endtask

  // write a register while the block is idle
  task cfg_write(input logic sel, input logic [CfgDataW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SCALE_ENABLE) cfg_scale = value[0];
    else cfg_threshold = value[ByteW-1:0];
  endtask

  // hold the sender until every expected word is out, then let the pipe settle
  task wait_for_results();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function logic [15:0] rand_coord(input logic is_x);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hffff;
    if (r == 2) begin
      return is_x ? 16'($urandom_range(780, 1040)) : 16'($urandom_range(460, 620));
    end
    if (r == 3) return 16'($urandom);
    return is_x ? 16'($urandom_range(0, PanelXFull)) : 16'($urandom_range(0, PanelYFull));
  endfunction

  // mostly well-formed reports, plus empty, not-ready and noise words
  task send_random_report();
    int unsigned kind;
    int unsigned cnt;
    int unsigned npts;
    logic [7:0]  sb;
    in_word_t    w;
    kind = $urandom_range(0, 99);
    sb = 8'($urandom);
    if (kind < 70) begin
      cnt = $urandom_range(1, MaxPointsDefault);
      sb[StatusReadyBit] = 1'b1;
      sb[3:0] = 4'(cnt);
      send_word(status_word(sb));
      npts = ($urandom_range(0, 19) == 0) ? $urandom_range(0, cnt - 1) : cnt;
      for (int p = 0; p < npts; p++) begin
        send_point(rand_coord(1'b1), rand_coord(1'b0), p != cnt - 1);
      end
      if ($urandom_range(0, 9) == 0) send_data(8'($urandom));
    end else if (kind < 85) begin
      cnt = $urandom_range(0, 10);
      if (cnt != 0) cnt = cnt + MaxPointsDefault;
      sb[StatusReadyBit] = 1'b1;
      sb[3:0] = 4'(cnt);
      send_word(status_word(sb));
    end else if (kind < 92) begin
      sb[StatusReadyBit] = 1'b0;
      send_word(status_word(sb));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        w.report_byte = 8'($urandom);
        w.report_start = 1'($urandom);
        w.read_failed = 1'($urandom);
        send_word(w);
      end
    end
  endtask

  // coordinate extremes and clamping with scaling off
  task test_points();
    send_word(status_word(8'h81));
    send_point(16'h0000, 16'h0000, 1'b0);
    send_data(8'haa);
    send_word(status_word(8'hf2));
    send_point(16'hffff, 16'hffff, 1'b1);
    send_point(16'd799, 16'd479, 1'b0);
    send_word(status_word(8'h81));
    send_point(16'd800, 16'd480, 1'b0);
  endtask

  // aborted, malformed and empty reports
  task test_special_cases();
    in_word_t w;
    // not-ready status, then a stray byte
    send_word(status_word(8'h01));
    send_data(8'h55);
    // new status in the middle of a record
    send_word(status_word(8'h82));
    send_data(8'h00);
    send_data(8'h12);
    send_word(status_word(8'h82));
    send_point(16'd100, 16'd200, 1'b1);
    // failed read mid-report, rest is ignored
    send_data(8'h01);
    w = status_word(8'h83);
    w.read_failed = 1'b1;
    send_word(w);
    send_data(8'h22);
    send_data(8'h01);
    // empty reports: zero count and counts above the maximum
    send_word(status_word(8'h80));
    send_word(status_word(8'h86));
    send_word(status_word(8'hff));
    send_word(status_word(8'h8f));
    wait_for_results();
    // lowest threshold: every empty report releases
    cfg_write(REG_RELEASE_THRESHOLD, 32'd1);
    send_word(status_word(8'h81));
    send_point(16'd3, 16'd4, 1'b0);
    send_word(status_word(8'h80));
    send_word(status_word(8'h8a));
  endtask

  // panel scaling at and beyond the raw range
  task test_scaling();
    wait_for_results();
    cfg_write(REG_SCALE_ENABLE, 32'd1);
    send_word(status_word(8'h84));
    send_point(16'd1023, 16'd599, 1'b1);
    send_point(16'd1024, 16'd600, 1'b1);
    send_point(16'hffff, 16'hffff, 1'b1);
    send_point(16'd512, 16'd300, 1'b0);
  endtask

  // release counter saturates instead of wrapping
  task test_release_saturation();
    wait_for_results();
    cfg_write(REG_SCALE_ENABLE, 32'd0);
    cfg_write(REG_RELEASE_THRESHOLD, 32'd255);
    send_word(status_word(8'h81));
    send_point(16'd10, 16'd20, 1'b0);
    repeat (260) send_word(status_word(8'h80));
  endtask

  // random reports under several idle patterns and register settings
  task test_random();
    int unsigned phase_end;
    int unsigned thr;
    corrupt_pct = 2;
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_results();
      case (ph)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
          thr = 3;
        end
        1: begin
          sender_idle_pct = 50;
          stall_pct = 0;
          thr = 1;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 50;
          thr = 255;
        end
        default: begin
          sender_idle_pct = 25;
          stall_pct = 25;
          thr = $urandom_range(1, 255);
        end
      endcase
      cfg_write(REG_SCALE_ENABLE, ph % 2);
      cfg_write(REG_RELEASE_THRESHOLD, thr);
      phase_end = bytes_sent + 350;
      while (bytes_sent < phase_end) send_random_report();
    end
    corrupt_pct = 0;
  endtask

  // output stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // compare each delivered word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported) begin
          $display("unexpected word: kind %0d idx %0d cnt %0d x %0d y %0d last %0d",
                   out_word.event_kind, out_word.point_index, out_word.touch_count,
                   out_word.point_x, out_word.point_y, out_word.last_point);
        end
      end else begin
        oldest_event = pending_events.pop_front();
        if (out_word !== oldest_event) begin
          error_count++;
          if (error_count <= MaxReported) begin
            $display("mismatch (exp/got): kind %0d/%0d idx %0d/%0d cnt %0d/%0d",
                     oldest_event.event_kind, out_word.event_kind,
                     oldest_event.point_index, out_word.point_index,
                     oldest_event.touch_count, out_word.touch_count);
            $display("  x %0d/%0d y %0d/%0d last %0d/%0d",
                     oldest_event.point_x, out_word.point_x,
                     oldest_event.point_y, out_word.point_y,
                     oldest_event.last_point, out_word.last_point);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_scale = 1'b0;
    cfg_threshold = ReleaseThresholdRst;
    rec_offset = '0;
    armed_count = '0;
    raw_x = '0;
    raw_y = '0;
    empty_reports = '0;
    bytes_sent = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    corrupt_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_points();
    test_special_cases();
    test_scaling();
    test_release_saturation();
    test_random();

    wait_for_results();
    if (error_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
